>>> src/b64sd_pkg.sv
// Shared types, constants and helpers for the base64 stream decoder.
`timescale 1ns / 1ps

package b64sd_pkg;

   // Field and register widths
   localparam int CHAR_W      = 8;
   localparam int VAL_W       = 6;
   localparam int BYTE_W      = 8;
   localparam int TOTAL_W     = 24;
   localparam int LIMIT_W     = 24;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 24;
   localparam int COUNT_WIDTH = 24;

   // Compare width: holds the count, the limit and the count plus up to three
   localparam int CMP_W = 34;
   localparam logic [CMP_W-1:0] COUNT_MAX = (CMP_W'(1) << COUNT_WIDTH) - CMP_W'(1);

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_SYMBOL_SIXTY_TWO   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SYMBOL_SIXTY_THREE = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_SYMBOL         = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_LIMIT       = 8'd3;

   // Register reset values
   localparam logic [CHAR_W-1:0]  RST_SIXTY_TWO   = 8'd43;   // '+'
   localparam logic [CHAR_W-1:0]  RST_SIXTY_THREE = 8'd47;   // '/'
   localparam logic [CHAR_W-1:0]  RST_PAD         = 8'd61;   // '='
   localparam logic [LIMIT_W-1:0] RST_LIMIT       = 24'hFF_FFFF;

   // Alphabet ranges
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [VAL_W-1:0]  VAL_LOWER_BASE = 6'd26;
   localparam logic [VAL_W-1:0]  VAL_DIGIT_BASE = 6'd52;
   localparam logic [VAL_W-1:0]  VAL_SIXTY_TWO  = 6'd62;
   localparam logic [VAL_W-1:0]  VAL_SIXTY_THREE = 6'd63;

   // Bit masks for splitting a group into bytes
   localparam logic [VAL_W-1:0] MASK_HI2  = 6'h30;
   localparam logic [VAL_W-1:0] MASK_MID4 = 6'h3C;
   localparam logic [VAL_W-1:0] MASK_LO4  = 6'h0F;
   localparam logic [VAL_W-1:0] MASK_LO2  = 6'h03;

   // Configurable symbols
   typedef struct packed {
      logic [CHAR_W-1:0] sixty_two;
      logic [CHAR_W-1:0] sixty_three;
      logic [CHAR_W-1:0] pad;
   } sym_cfg_type;

   // Decoded character
   typedef struct packed {
      logic              stop;
      logic [VAL_W-1:0]  value;
   } char_code_type;

   typedef logic [VAL_W-1:0]  group_type [4];
   typedef logic [BYTE_W-1:0] bytes_type [3];

   // Four 6-bit values to three bytes
   function automatic bytes_type group_bytes(input group_type g);
      bytes_type b;
      logic [VAL_W-1:0] m1;
      logic [VAL_W-1:0] m2;
      logic [VAL_W-1:0] m3;
      logic [VAL_W-1:0] m4;
      m1 = (g[1] & MASK_HI2) >> 4;
      m2 = g[1] & MASK_LO4;
      m3 = (g[2] & MASK_MID4) >> 2;
      m4 = g[2] & MASK_LO2;
      b[0] = {g[0], m1[1:0]};
      b[1] = {m2[3:0], m3[3:0]};
      b[2] = {m4[1:0], g[3]};
      return b;
   endfunction

endpackage

>>> src/b64sd_char_map.sv
// Character to 6-bit value map with configurable symbols and pad.
`timescale 1ns / 1ps

module b64sd_char_map (
   input  logic [b64sd_pkg::CHAR_W-1:0] in_char,
   input  b64sd_pkg::sym_cfg_type       sym_cfg,
   output b64sd_pkg::char_code_type     code
);

   // Pad wins over everything, letters and digits over the symbols
   always_comb begin
      code.stop  = 1'b0;
      code.value = '0;
      if (in_char == sym_cfg.pad) begin
         code.stop = 1'b1;
      end else if (in_char inside {[b64sd_pkg::CHAR_UPPER_A : b64sd_pkg::CHAR_UPPER_Z]}) begin
         code.value = b64sd_pkg::VAL_W'(in_char - b64sd_pkg::CHAR_UPPER_A);
      end else if (in_char inside {[b64sd_pkg::CHAR_LOWER_A : b64sd_pkg::CHAR_LOWER_Z]}) begin
         code.value = b64sd_pkg::VAL_W'(in_char - b64sd_pkg::CHAR_LOWER_A)
                      + b64sd_pkg::VAL_LOWER_BASE;
      end else if (in_char inside {[b64sd_pkg::CHAR_DIGIT_0 : b64sd_pkg::CHAR_DIGIT_9]}) begin
         code.value = b64sd_pkg::VAL_W'(in_char - b64sd_pkg::CHAR_DIGIT_0)
                      + b64sd_pkg::VAL_DIGIT_BASE;
      end else if (in_char == sym_cfg.sixty_two) begin
         code.value = b64sd_pkg::VAL_SIXTY_TWO;
      end else if (in_char == sym_cfg.sixty_three) begin
         code.value = b64sd_pkg::VAL_SIXTY_THREE;
      end else begin
         code.stop = 1'b1;
      end
   end

endmodule

>>> src/base64_stream_decoder_top.sv
// Base64 stream decoder: input register, decode, result buffer, output sequencing.
// An accepted item is decoded in the cycle after acceptance, from the input register; its first
//   result shows on rsp_ once the item is written into the result buffer, when that buffer is free.
// Throughput: one item per cycle while items give at most one result and rsp_ready is high;
//   an item with k results holds the result buffer until all k are taken, at most one per cycle.
// Reset (synchronous, active high) clears the group, counters and buffers and returns
//   the registers to '+', '/', '=' and a limit of 0xFFFFFF.
`timescale 1ns / 1ps

module base64_stream_decoder_top (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [b64sd_pkg::CHAR_W-1:0]      req_in_char,
   input  logic                              req_end_of_string,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [b64sd_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                              rsp_is_data,
   output logic                              rsp_run_last,
   output logic                              rsp_stream_done,
   output logic                              rsp_overflow_error,
   output logic [b64sd_pkg::TOTAL_W-1:0]     rsp_byte_total,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [b64sd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [b64sd_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int CW = b64sd_pkg::COUNT_WIDTH;
   localparam int XW = b64sd_pkg::CMP_W;

   // Configuration registers
   b64sd_pkg::sym_cfg_type              sym_ff;
   logic [b64sd_pkg::LIMIT_W-1:0]       limit_ff;

   // Input register
   logic                                in_valid_ff;
   logic [b64sd_pkg::CHAR_W-1:0]        in_char_ff;
   logic                                in_eos_ff;

   // Decoder state
   logic [b64sd_pkg::VAL_W-1:0]         vals_ff [3];
   logic [1:0]                          fill_ff;
   logic                                stopped_ff;
   logic [CW-1:0]                       count_ff;
   logic                                ovf_ff;

   // Result buffer
   logic [b64sd_pkg::BYTE_W-1:0]        buf_byte_ff [3];
   logic [1:0]                          buf_nbytes_ff;
   logic [CW-1:0]                       buf_base_ff;
   logic                                buf_data_ovf_ff;
   logic                                buf_done_ovf_ff;
   logic [1:0]                          buf_ptr_ff;
   logic [2:0]                          buf_left_ff;

   b64sd_pkg::char_code_type            code;
   logic                                take;
   logic                                buf_free;
   logic                                process;
   logic                                take_char;
   logic                                full;
   logic [b64sd_pkg::VAL_W-1:0]         vals_upd [3];
   logic [1:0]                          fill_after;
   b64sd_pkg::group_type                grp;
   b64sd_pkg::bytes_type                bytes;
   logic [1:0]                          n_cand;
   logic [1:0]                          n_emit;
   logic [XW-1:0]                       count_x;
   logic [XW-1:0]                       cap_x;
   logic [2:0]                          room_ok;
   logic                                ovf_after;
   logic [CW-1:0]                       count_after;
   logic [XW-1:0]                       total_x;

   b64sd_char_map u_char_map (
      .in_char (in_char_ff),
      .sym_cfg (sym_ff),
      .code    (code)
   );

   // Handshakes
   assign csr_ready = 1'b1;
   assign rsp_valid = (buf_left_ff != 3'd0);
   assign take      = rsp_valid && rsp_ready;
   assign buf_free  = (buf_left_ff == 3'd0) || ((buf_left_ff == 3'd1) && take);
   assign process   = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || process;

   // Decode of the registered item
   always_comb begin
      take_char = !stopped_ff && !code.stop;
      full      = take_char && (fill_ff == 2'd3);
      vals_upd  = vals_ff;
      if (take_char && !full) begin
         vals_upd[fill_ff] = code.value;
      end
      if (full) begin
         fill_after = 2'd0;
      end else if (take_char) begin
         fill_after = 2'(fill_ff + 2'd1);
      end else begin
         fill_after = fill_ff;
      end
      // full group, or the partial group on end of string (zeros beyond the fill)
      if (full) begin
         grp[0] = vals_ff[0];
         grp[1] = vals_ff[1];
         grp[2] = vals_ff[2];
         grp[3] = code.value;
      end else begin
         grp[0] = vals_upd[0];
         grp[1] = vals_upd[1];
         grp[2] = vals_upd[2];
         grp[3] = '0;
      end
      bytes = b64sd_pkg::group_bytes(grp);
      if (full) begin
         n_cand = 2'd3;
      end else if (in_eos_ff && (fill_after > 2'd1)) begin
         n_cand = 2'(fill_after - 2'd1);
      end else begin
         n_cand = 2'd0;
      end
   end

   // Limit check: bytes are kept while the count stays below the cap
   always_comb begin
      count_x = XW'(count_ff);
      cap_x   = (XW'(limit_ff) < b64sd_pkg::COUNT_MAX) ? XW'(limit_ff)
                                                        : b64sd_pkg::COUNT_MAX;
      for (int i = 0; i < 3; i++) begin
         room_ok[i] = (count_x + XW'(i)) < cap_x;
      end
      n_emit = 2'd0;
      for (int i = 0; i < 3; i++) begin
         if ((2'(i) < n_cand) && room_ok[i]) begin
            n_emit = 2'(i + 1);
         end
      end
      ovf_after   = ovf_ff || (n_emit != n_cand);
      count_after = count_ff + CW'(n_emit);
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff.sixty_two   <= b64sd_pkg::RST_SIXTY_TWO;
         sym_ff.sixty_three <= b64sd_pkg::RST_SIXTY_THREE;
         sym_ff.pad         <= b64sd_pkg::RST_PAD;
         limit_ff           <= b64sd_pkg::RST_LIMIT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            b64sd_pkg::REG_SYMBOL_SIXTY_TWO:   sym_ff.sixty_two   <= csr_data[7:0];
            b64sd_pkg::REG_SYMBOL_SIXTY_THREE: sym_ff.sixty_three <= csr_data[7:0];
            b64sd_pkg::REG_PAD_SYMBOL:         sym_ff.pad         <= csr_data[7:0];
            b64sd_pkg::REG_OUTPUT_LIMIT:       limit_ff           <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_char_ff <= req_in_char;
         in_eos_ff  <= req_end_of_string;
      end
   end

   // Decoder state; end of string rearms for the next string
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) vals_ff[i] <= '0;
         fill_ff    <= 2'd0;
         stopped_ff <= 1'b0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
      end else if (process) begin
         if (in_eos_ff) begin
            for (int i = 0; i < 3; i++) vals_ff[i] <= '0;
            fill_ff    <= 2'd0;
            stopped_ff <= 1'b0;
            count_ff   <= '0;
            ovf_ff     <= 1'b0;
         end else begin
            for (int i = 0; i < 3; i++) vals_ff[i] <= full ? '0 : vals_upd[i];
            fill_ff    <= fill_after;
            stopped_ff <= stopped_ff || code.stop;
            count_ff   <= count_after;
            ovf_ff     <= ovf_after;
         end
      end
   end

   // Result buffer: kept bytes, then the done item on end of string
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ptr_ff  <= 2'd0;
         buf_left_ff <= 3'd0;
      end else if (process) begin
         buf_ptr_ff  <= 2'd0;
         buf_left_ff <= 3'(n_emit) + 3'(in_eos_ff);
      end else if (take) begin
         buf_ptr_ff  <= 2'(buf_ptr_ff + 2'd1);
         buf_left_ff <= 3'(buf_left_ff - 3'd1);
      end
      if (process) begin
         for (int i = 0; i < 3; i++) buf_byte_ff[i] <= bytes[i];
         buf_nbytes_ff   <= n_emit;
         buf_base_ff     <= count_ff;
         buf_data_ovf_ff <= ovf_ff;
         buf_done_ovf_ff <= ovf_after;
      end
   end

   // Output fields of the current buffer entry
   always_comb begin
      rsp_run_last = (buf_left_ff == 3'd1);
      if (buf_ptr_ff < buf_nbytes_ff) begin
         case (buf_ptr_ff)
            2'd0:    rsp_out_byte = buf_byte_ff[0];
            2'd1:    rsp_out_byte = buf_byte_ff[1];
            default: rsp_out_byte = buf_byte_ff[2];
         endcase
         rsp_is_data        = 1'b1;
         rsp_stream_done    = 1'b0;
         rsp_overflow_error = buf_data_ovf_ff;
         total_x            = XW'(buf_base_ff) + XW'(buf_ptr_ff) + XW'(1);
      end else begin
         rsp_out_byte       = '0;
         rsp_is_data        = 1'b0;
         rsp_stream_done    = 1'b1;
         rsp_overflow_error = buf_done_ovf_ff;
         total_x            = XW'(buf_base_ff) + XW'(buf_nbytes_ff);
      end
      rsp_byte_total = total_x[b64sd_pkg::TOTAL_W-1:0];
   end

   // Checks
   a_buf_depth: assert property (@(posedge clock) disable iff (reset)
      buf_left_ff <= 3'd4)
      else $error("result buffer holds more than four items");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_run_last)
      else $error("done item is not the last of its input");

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      process && in_eos_ff |=> (fill_ff == 2'd0) && !stopped_ff && (count_ff == '0))
      else $error("decoder not rearmed after end of string");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !process |=> in_valid_ff && $stable(in_char_ff))
      else $error("pending item lost from input register");

endmodule

>>> test/b64sd_checker.sv
// Checker for the base64 stream decoder: tracks registers, predicts results, compares.
`timescale 1ns / 1ps

module b64sd_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [b64sd_pkg::CHAR_W-1:0]        req_in_char,
   input  logic                                req_end_of_string,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [b64sd_pkg::BYTE_W-1:0]        rsp_out_byte,
   input  logic                                rsp_is_data,
   input  logic                                rsp_run_last,
   input  logic                                rsp_stream_done,
   input  logic                                rsp_overflow_error,
   input  logic [b64sd_pkg::TOTAL_W-1:0]       rsp_byte_total,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [b64sd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [b64sd_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                  fault_count,
   output int                                  owed_count
);

   // Stop flag sits above the 6-bit value
   localparam logic [b64sd_pkg::VAL_W:0] STOP_CODE = 7'h40;
   localparam int                        REPORT_MAX = 10;

   typedef struct packed {
      logic [b64sd_pkg::BYTE_W-1:0]  data_byte;
      logic                          is_data;
      logic                          run_last;
      logic                          stream_done;
      logic                          overflow_error;
      logic [b64sd_pkg::TOTAL_W-1:0] byte_total;
   } dec_result_type;

   // Register copies
   logic [b64sd_pkg::CHAR_W-1:0]  sym62;
   logic [b64sd_pkg::CHAR_W-1:0]  sym63;
   logic [b64sd_pkg::CHAR_W-1:0]  pad_sym;
   logic [b64sd_pkg::LIMIT_W-1:0] limit;

   // Decoder state
   logic [b64sd_pkg::VAL_W-1:0]   grp [4];
   int                            fill;
   bit                            halted;
   logic [b64sd_pkg::TOTAL_W-1:0] written;
   bit                            dropped;

   dec_result_type owed_q [$];
   int             faults = 0;

   // Character to 6-bit value; pad wins, then letters and digits, then symbols
   function automatic logic [b64sd_pkg::VAL_W:0] char_code(
      input logic [b64sd_pkg::CHAR_W-1:0] c);
      if (c == pad_sym)
         return STOP_CODE;
      if (c >= b64sd_pkg::CHAR_UPPER_A && c <= b64sd_pkg::CHAR_UPPER_Z)
         return {1'b0, b64sd_pkg::VAL_W'(c - b64sd_pkg::CHAR_UPPER_A)};
      if (c >= b64sd_pkg::CHAR_LOWER_A && c <= b64sd_pkg::CHAR_LOWER_Z)
         return {1'b0, b64sd_pkg::VAL_W'(c - b64sd_pkg::CHAR_LOWER_A)
                       + b64sd_pkg::VAL_LOWER_BASE};
      if (c >= b64sd_pkg::CHAR_DIGIT_0 && c <= b64sd_pkg::CHAR_DIGIT_9)
         return {1'b0, b64sd_pkg::VAL_W'(c - b64sd_pkg::CHAR_DIGIT_0)
                       + b64sd_pkg::VAL_DIGIT_BASE};
      if (c == sym62)
         return {1'b0, b64sd_pkg::VAL_SIXTY_TWO};
      if (c == sym63)
         return {1'b0, b64sd_pkg::VAL_SIXTY_THREE};
      return STOP_CODE;
   endfunction

   task automatic clear_string();
      for (int i = 0; i < 4; i++) grp[i] = '0;
      fill    = 0;
      halted  = 1'b0;
      written = '0;
      dropped = 1'b0;
   endtask

   // One decoded byte, dropped once the limit is hit
   task automatic put_byte(input logic [b64sd_pkg::BYTE_W-1:0] b, inout int k);
      if (written >= limit) begin
         dropped = 1'b1;
      end else begin
         written = written + 1'b1;
         owed_q.push_back('{b, 1'b1, 1'b0, 1'b0, dropped, written});
         k++;
      end
   endtask

   // First nbytes bytes of the current group
   task automatic flush_group(input int nbytes, inout int k);
      logic [b64sd_pkg::BYTE_W-1:0] b [3];
      b[0] = {grp[0], grp[1][5:4]};
      b[1] = {grp[1][3:0], grp[2][5:2]};
      b[2] = {grp[2][1:0], grp[3]};
      for (int i = 0; i < nbytes; i++) put_byte(b[i], k);
   endtask

   // Results caused by one input item
   task automatic predict_decode(input logic [b64sd_pkg::CHAR_W-1:0] c, input logic eos);
      logic [b64sd_pkg::VAL_W:0] code;
      dec_result_type            r;
      int                        k;
      k = 0;
      if (!halted) begin
         code = char_code(c);
         if (code[b64sd_pkg::VAL_W]) begin
            halted = 1'b1;
         end else begin
            grp[fill] = code[b64sd_pkg::VAL_W-1:0];
            if (fill == 3) begin
               flush_group(3, k);
               fill = 0;
               for (int i = 0; i < 4; i++) grp[i] = '0;
            end else begin
               fill++;
            end
         end
      end
      // end of string: partial group, then the done item
      if (eos) begin
         if (fill > 1) begin
            for (int i = fill; i < 4; i++) grp[i] = '0;
            flush_group(fill - 1, k);
         end
         owed_q.push_back('{'0, 1'b0, 1'b0, 1'b1, dropped, written});
         k++;
         clear_string();
      end
      if (k > 0) begin
         r = owed_q.pop_back();
         r.run_last = 1'b1;
         owed_q.push_back(r);
      end
   endtask

   task automatic check_result(input dec_result_type got);
      dec_result_type want;
      if (owed_q.size() == 0) begin
         faults++;
         if (faults <= REPORT_MAX)
            $display({"unexpected item: byte %02h data %0b last %0b done %0b",
                      " ovf %0b total %0d"},
                     got.data_byte, got.is_data, got.run_last, got.stream_done,
                     got.overflow_error, got.byte_total);
      end else begin
         want = owed_q.pop_front();
         if (got.data_byte !== want.data_byte || got.is_data !== want.is_data ||
             got.run_last !== want.run_last || got.stream_done !== want.stream_done ||
             got.overflow_error !== want.overflow_error ||
             got.byte_total !== want.byte_total) begin
            faults++;
            if (faults <= REPORT_MAX) begin
               $display({"mismatch expected: byte %02h data %0b last %0b done %0b",
                         " ovf %0b total %0d"},
                        want.data_byte, want.is_data, want.run_last, want.stream_done,
                        want.overflow_error, want.byte_total);
               $display({"         actual:   byte %02h data %0b last %0b done %0b",
                         " ovf %0b total %0d"},
                        got.data_byte, got.is_data, got.run_last, got.stream_done,
                        got.overflow_error, got.byte_total);
            end
         end
      end
   endtask

   // Watch all three channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         sym62   = b64sd_pkg::RST_SIXTY_TWO;
         sym63   = b64sd_pkg::RST_SIXTY_THREE;
         pad_sym = b64sd_pkg::RST_PAD;
         limit   = b64sd_pkg::RST_LIMIT;
         clear_string();
         owed_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               b64sd_pkg::REG_SYMBOL_SIXTY_TWO:
                  sym62   = csr_data[b64sd_pkg::CHAR_W-1:0];
               b64sd_pkg::REG_SYMBOL_SIXTY_THREE:
                  sym63   = csr_data[b64sd_pkg::CHAR_W-1:0];
               b64sd_pkg::REG_PAD_SYMBOL:
                  pad_sym = csr_data[b64sd_pkg::CHAR_W-1:0];
               b64sd_pkg::REG_OUTPUT_LIMIT:
                  limit   = csr_data[b64sd_pkg::LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_decode(req_in_char, req_end_of_string);
         if (rsp_valid && rsp_ready)
            check_result('{rsp_out_byte, rsp_is_data, rsp_run_last, rsp_stream_done,
                           rsp_overflow_error, rsp_byte_total});
      end
      fault_count <= faults;
      owed_count  <= owed_q.size();
   end

endmodule

>>> test/tb_top.sv
// Testbench top for the base64 stream decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic [b64sd_pkg::CSR_IDX_W-1:0] REG_FIRST_UNUSED =
      b64sd_pkg::REG_OUTPUT_LIMIT + 1'b1;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [b64sd_pkg::CHAR_W-1:0]        req_in_char;
   logic                                req_end_of_string;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [b64sd_pkg::BYTE_W-1:0]        rsp_out_byte;
   logic                                rsp_is_data;
   logic                                rsp_run_last;
   logic                                rsp_stream_done;
   logic                                rsp_overflow_error;
   logic [b64sd_pkg::TOTAL_W-1:0]       rsp_byte_total;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [b64sd_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [b64sd_pkg::CSR_DATA_W-1:0]    csr_data;

   int fault_count;
   int owed_count;
   int cycle_count = 0;
   int ready_hold  = 0;
   bit quiet = 1'b0;
   int items_sent;

   // Current symbols, used to build well-formed strings
   logic [b64sd_pkg::CHAR_W-1:0] sym62_now;
   logic [b64sd_pkg::CHAR_W-1:0] sym63_now;
   logic [b64sd_pkg::CHAR_W-1:0] pad_now;

   always #(HALF_PERIOD) clock = ~clock;

   base64_stream_decoder_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_char        (req_in_char),
      .req_end_of_string  (req_end_of_string),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_is_data        (rsp_is_data),
      .rsp_run_last       (rsp_run_last),
      .rsp_stream_done    (rsp_stream_done),
      .rsp_overflow_error (rsp_overflow_error),
      .rsp_byte_total     (rsp_byte_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   b64sd_checker decode_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_char        (req_in_char),
      .req_end_of_string  (req_end_of_string),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_is_data        (rsp_is_data),
      .rsp_run_last       (rsp_run_last),
      .rsp_stream_done    (rsp_stream_done),
      .rsp_overflow_error (rsp_overflow_error),
      .rsp_byte_total     (rsp_byte_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fault_count        (fault_count),
      .owed_count         (owed_count)
   );

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // Result side back-pressure: rsp_ready drops at random, and stays high while quiet is set
   always @(posedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // One character item, with an occasional gap before it
   task automatic send_char(input logic [b64sd_pkg::CHAR_W-1:0] c, input logic eos);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_in_char       <= c;
      req_end_of_string <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // Map a 6-bit value to a character under the current symbols
   function automatic logic [b64sd_pkg::CHAR_W-1:0] value_char(input int v);
      if (v < 26) return b64sd_pkg::CHAR_UPPER_A + b64sd_pkg::CHAR_W'(v);
      if (v < 52) return b64sd_pkg::CHAR_LOWER_A + b64sd_pkg::CHAR_W'(v - 26);
      if (v < 62) return b64sd_pkg::CHAR_DIGIT_0 + b64sd_pkg::CHAR_W'(v - 52);
      if (v == 62) return sym62_now;
      return sym63_now;
   endfunction

   // One string: mostly well formed, some with a pad inside, some pure noise
   task automatic send_string();
      logic [b64sd_pkg::CHAR_W-1:0] chars [16];
      int kind;
      int n;
      int len;
      kind = $urandom_range(0, 9);
      if (kind >= 8) begin
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++)
            chars[i] = b64sd_pkg::CHAR_W'($urandom_range(0, 255));
         items_sent += len;
      end else begin
         n = $urandom_range(0, 11);
         for (int i = 0; i < n; i++) chars[i] = value_char($urandom_range(0, 63));
         len = n;
         if (n % 4 >= 2 && $urandom_range(0, 1) == 1) begin
            chars[len] = pad_now;
            len++;
            if (n % 4 == 2) begin
               chars[len] = pad_now;
               len++;
            end
         end
         if (kind == 7 && n > 1) chars[$urandom_range(0, n - 1)] = pad_now;
         if (len == 0) begin
            chars[0] = pad_now;
            len = 1;
         end
         items_sent += len;
      end
      for (int i = 0; i < len; i++) send_char(chars[i], i == len - 1);
   endtask

   task automatic run_random(input int target);
      items_sent = 0;
      while (items_sent < target) send_string();
   endtask

   // Hold off input until every expected item is out, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [b64sd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [b64sd_pkg::CSR_DATA_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // All four registers, junk in the unused data bits of the symbol writes, optional stray write
   task automatic set_regs(input logic [b64sd_pkg::CHAR_W-1:0] s62,
                           input logic [b64sd_pkg::CHAR_W-1:0] s63,
                           input logic [b64sd_pkg::CHAR_W-1:0] pad,
                           input logic [b64sd_pkg::LIMIT_W-1:0] lim,
                           input bit stray_write);
      write_reg(b64sd_pkg::REG_SYMBOL_SIXTY_TWO,   {16'($urandom), s62});
      write_reg(b64sd_pkg::REG_SYMBOL_SIXTY_THREE, {16'($urandom), s63});
      write_reg(b64sd_pkg::REG_PAD_SYMBOL,         {16'($urandom), pad});
      write_reg(b64sd_pkg::REG_OUTPUT_LIMIT,       lim);
      if (stray_write)
         write_reg(b64sd_pkg::CSR_IDX_W'($urandom_range(REG_FIRST_UNUSED,
                                                         {b64sd_pkg::CSR_IDX_W{1'b1}})),
                   b64sd_pkg::CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      sym62_now = s62;
      sym63_now = s63;
      pad_now   = pad;
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_in_char       <= '0;
      req_end_of_string <= 1'b0;
      csr_valid         <= 1'b0;
      csr_index         <= '0;
      csr_data          <= '0;
      sym62_now = b64sd_pkg::RST_SIXTY_TWO;
      sym63_now = b64sd_pkg::RST_SIXTY_THREE;
      pad_now   = b64sd_pkg::RST_PAD;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed strings under the reset symbols
      send_text("AAAA////");   // all-zero and all-one bytes, two full groups plus done
      send_text("+/9zAz==");   // both symbols, pad stop, second pad ignored
      send_text("Q");          // lone value gives no byte
      send_text("AB!");        // stopping character carries the end flag
      send_text("E#Z");        // characters after a stop are ignored
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      settle();

      // URL-style symbols, small limit
      set_regs(8'h2D, 8'h5F, 8'h2E, 24'd5, 1'b0);
      run_random(60);
      settle();

      // Equal symbols at zero, pad at the top code, nothing may be written
      set_regs(8'h00, 8'h00, 8'hFF, 24'd0, 1'b0);
      run_random(40);
      settle();

      // Pad on a letter, value 63 symbol on a digit
      set_regs(8'hFF, 8'h39, 8'h41, 24'd7, 1'b0);
      run_random(50);
      settle();

      // Back to standard symbols with the largest limit, plus a write to no register
      set_regs(b64sd_pkg::RST_SIXTY_TWO, b64sd_pkg::RST_SIXTY_THREE, b64sd_pkg::RST_PAD,
               {b64sd_pkg::LIMIT_W{1'b1}}, 1'b1);
      run_random(25);
      quiet <= 1'b1;
      run_random(25);
      settle();

      if (owed_count != 0)
         $display("%0d expected items never arrived", owed_count);
      if (fault_count == 0 && owed_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
